[design/cmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmc_pkg
// shared constants and types for the colour marker centroid detector
// ----------------------------------------------------------------------------
package cmc_pkg;

    localparam int PALETTE_SIZE    = 6;
    localparam int MAX_FRAME_WIDTH = 4096;

    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;
    localparam int FW_W     = $clog2(MAX_FRAME_WIDTH) + 1;
    localparam int POS_W    = $clog2(MAX_FRAME_WIDTH);
    localparam int ID_W     = 3;
    localparam int SEEN_W   = $clog2(PALETTE_SIZE + 1);
    localparam int LIMIT_W  = 2 * POS_W;
    localparam int CNT_W    = LIMIT_W + 1;
    localparam int SUM_W    = LIMIT_W + POS_W;
    localparam int FRAC_W   = 4;
    localparam int Q_W      = 16;
    localparam int DVD_W    = SUM_W + FRAC_W + 1;
    localparam int STEP_W   = $clog2(Q_W);

    localparam int S_DATA_W = ((PIX_W + 7) / 8) * 8;
    localparam int M_BITS   = ID_W + 2 * Q_W;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PIX_W;

    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(1) << LIMIT_W;
    localparam logic [FW_W-1:0]  FW_MAX      = FW_W'(MAX_FRAME_WIDTH);
    localparam logic [FW_W-1:0]  FW_RESET    = FW_W'(640);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_BASE = CFG_IDX_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

endpackage

[design/color_marker_centroid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_marker_centroid
// colour marker centroid detector: per-colour pixel statistics over a frame,
// centroids by a shared restoring divider at frame end
// ----------------------------------------------------------------------------
// Pixels are taken at one per clock. The request marked last ends the frame:
// from then on s_tready is low while one 16-step restoring divider, shared
// by all colours and both axes, works out each centroid. Each centroid is
// offered after the last pixel or the previous handover once a load state
// and 16 divide steps have run for x, then the same for y; a frame with no
// marker offers its single result in the cycle after the last pixel. The
// block takes pixels again in the cycle after the last result of the frame
// is handed over.
// ----------------------------------------------------------------------------
module color_marker_centroid (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cmc_pkg::S_DATA_W-1:0]    s_tdata,   // blue, green, red
    input  logic                            s_tlast,   // frame_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cmc_pkg::M_DATA_W-1:0]    m_tdata,   // color_id, centroid_x, centroid_y
    output logic                            m_tuser,   // feature_valid
    output logic                            m_tlast,   // last_feature
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cmc_pkg::*;

    state_t                 state_reg, state_next;
    logic [FW_W-1:0]        fw_reg, fw_next;
    logic [PIX_W-1:0]       pal_reg [PALETTE_SIZE];
    logic [PIX_W-1:0]       pal_next [PALETTE_SIZE];
    logic [CNT_W-1:0]       cnt_reg [PALETTE_SIZE];
    logic [CNT_W-1:0]       cnt_next [PALETTE_SIZE];
    logic [SUM_W-1:0]       xsum_reg [PALETTE_SIZE];
    logic [SUM_W-1:0]       xsum_next [PALETTE_SIZE];
    logic [SUM_W-1:0]       ysum_reg [PALETTE_SIZE];
    logic [SUM_W-1:0]       ysum_next [PALETTE_SIZE];
    logic [ID_W-1:0]        order_reg [PALETTE_SIZE];
    logic [ID_W-1:0]        order_next [PALETTE_SIZE];
    logic [SEEN_W-1:0]      seen_reg, seen_next;
    logic [POS_W-1:0]       col_reg, col_next;
    logic [POS_W-1:0]       row_reg, row_next;
    logic [SEEN_W-1:0]      out_idx_reg, out_idx_next;
    logic                   axis_reg, axis_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]       den_reg, den_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [Q_W-1:0]         quo_reg, quo_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [Q_W-1:0]         cx_reg, cx_next;
    logic [Q_W-1:0]         cy_reg, cy_next;
    logic                   fv_reg, fv_next;
    logic                   last_reg, last_next;

    logic [PIX_W-1:0]       pix;
    logic                   hit;
    logic [ID_W-1:0]        hit_idx;
    logic [FW_W-1:0]        fw_eff;
    logic                   wrap;

    assign pix       = s_tdata[PIX_W-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {(M_DATA_W - M_BITS)'(0), cy_reg, cx_reg, id_reg};
    assign m_tuser   = fv_reg;
    assign m_tlast   = last_reg;

    // lowest matching palette entry wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = PALETTE_SIZE - 1; i >= 0; i--) begin
            if (pal_reg[i] != '0 && pal_reg[i] == pix) begin
                hit     = 1'b1;
                hit_idx = ID_W'(i);
            end
        end
    end

    always_comb begin
        if (fw_reg == '0) begin
            fw_eff = FW_W'(1);
        end else if (fw_reg > FW_MAX) begin
            fw_eff = FW_MAX;
        end else begin
            fw_eff = fw_reg;
        end
        wrap = ({1'b0, col_reg} + FW_W'(1)) >= fw_eff;
    end

    always_comb begin
        logic [ID_W-1:0]    sel_id;
        logic [SUM_W-1:0]   sel_sum;
        logic [DVD_W-1:0]   dvd;
        logic [CNT_W:0]     trial;
        logic               ge;

        state_next   = state_reg;
        fw_next      = fw_reg;
        pal_next     = pal_reg;
        cnt_next     = cnt_reg;
        xsum_next    = xsum_reg;
        ysum_next    = ysum_reg;
        order_next   = order_reg;
        seen_next    = seen_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        out_idx_next = out_idx_reg;
        axis_next    = axis_reg;
        step_next    = step_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        id_next      = id_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        fv_next      = fv_reg;
        last_next    = last_reg;

        sel_id  = order_reg[out_idx_reg[ID_W-1:0]];
        sel_sum = axis_reg ? ysum_reg[sel_id] : xsum_reg[sel_id];
        dvd     = {1'b0, sel_sum, FRAC_W'(0)} + DVD_W'(cnt_reg[sel_id] >> 1);
        trial   = {rem_reg, quo_reg[Q_W-1]};
        ge      = trial >= {1'b0, den_reg};

        if (cfg_valid) begin
            if (cfg_index == CFG_FRAME_WIDTH) begin
                fw_next = cfg_data[FW_W-1:0];
            end else if (cfg_index >= CFG_PALETTE_BASE &&
                         cfg_index < CFG_PALETTE_BASE + CFG_IDX_W'(PALETTE_SIZE)) begin
                pal_next[ID_W'(cfg_index - CFG_PALETTE_BASE)] = cfg_data;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (hit && cnt_reg[hit_idx] == '0 && seen_reg < SEEN_W'(PALETTE_SIZE)) begin
                        order_next[seen_reg[ID_W-1:0]] = hit_idx;
                        seen_next = seen_reg + SEEN_W'(1);
                    end
                    if (hit && cnt_reg[hit_idx] < COUNT_LIMIT) begin
                        cnt_next[hit_idx]  = cnt_reg[hit_idx] + CNT_W'(1);
                        xsum_next[hit_idx] = xsum_reg[hit_idx] + SUM_W'(col_reg);
                        ysum_next[hit_idx] = ysum_reg[hit_idx] + SUM_W'(row_reg);
                    end
                    if (wrap) begin
                        col_next = '0;
                        row_next = row_reg + POS_W'(1);
                    end else begin
                        col_next = col_reg + POS_W'(1);
                    end
                    if (s_tlast) begin
                        col_next     = '0;
                        row_next     = '0;
                        out_idx_next = '0;
                        axis_next    = 1'b0;
                        if (seen_next == '0) begin
                            fv_next    = 1'b0;
                            id_next    = '0;
                            cx_next    = '0;
                            cy_next    = '0;
                            last_next  = 1'b1;
                            state_next = ST_OUT;
                        end else begin
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD: begin
                id_next    = sel_id;
                den_next   = cnt_reg[sel_id];
                rem_next   = dvd[DVD_W-1:Q_W];
                quo_next   = dvd[Q_W-1:0];
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next  = ge ? CNT_W'(trial - {1'b0, den_reg}) : CNT_W'(trial);
                quo_next  = {quo_reg[Q_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(Q_W - 1)) begin
                    if (!axis_reg) begin
                        cx_next    = quo_next;
                        axis_next  = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        cy_next    = quo_next;
                        fv_next    = 1'b1;
                        last_next  = (out_idx_reg + SEEN_W'(1)) == seen_reg;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (last_reg) begin
                        for (int i = 0; i < PALETTE_SIZE; i++) begin
                            cnt_next[i]  = '0;
                            xsum_next[i] = '0;
                            ysum_next[i] = '0;
                        end
                        seen_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + SEEN_W'(1);
                        axis_next    = 1'b0;
                        state_next   = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fw_reg      <= FW_RESET;
            pal_reg     <= '{default: '0};
            cnt_reg     <= '{default: '0};
            xsum_reg    <= '{default: '0};
            ysum_reg    <= '{default: '0};
            seen_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            out_idx_reg <= '0;
            axis_reg    <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            fw_reg      <= fw_next;
            pal_reg     <= pal_next;
            cnt_reg     <= cnt_next;
            xsum_reg    <= xsum_next;
            ysum_reg    <= ysum_next;
            seen_reg    <= seen_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            out_idx_reg <= out_idx_next;
            axis_reg    <= axis_next;
            step_reg    <= step_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        order_reg <= order_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        id_reg    <= id_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        fv_reg    <= fv_next;
        last_reg  <= last_next;
    end

    a_pixel_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast |=> state_reg == ST_IDLE)
        else $error("ordinary pixel left the idle state");

    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= SEEN_W'(PALETTE_SIZE))
        else $error("seen colour count beyond palette size");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("empty result not marked last");

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_store_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> seen_reg == '0 && state_reg == ST_IDLE)
        else $error("store not cleared after frame results");

endmodule
